FILE: design/rqt_pkg.sv
// Package for the read quality trimmer: widths, codes, base type and error-probability table.
package rqt_pkg;

    // Field and register widths
    localparam int QUAL_W     = 7;   // phred quality
    localparam int PROB_W     = 17;  // Q0.16 probability, 1.0 included
    localparam int MINP_W     = 16;  // min_prob register
    localparam int AVG_W      = 7;   // min_avg_qual register
    localparam int LEN_W      = 13;  // positions, lengths, trim bounds
    localparam int SUM_W      = 32;  // running score sum
    localparam int QSUM_W     = 19;  // running quality total
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PROB_TBL_N = 52;  // qualities at or above this map to zero

    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
    localparam logic [QSUM_W-1:0] QSUM_MAX = '1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_PROB     = 3'd0,
        CFG_MIN_AVG_QUAL = 3'd1,
        CFG_MIN_LENGTH   = 3'd2,
        CFG_FIRST_POS    = 3'd3,
        CFG_LAST_POS     = 3'd4
    } t_cfg_idx;

    // One base as it travels through the input register
    typedef struct packed {
        logic [QUAL_W-1:0] quality;
        logic              is_last;
    } t_base;

    // round(65536 * 10^(-q/10)) for q = 0..51
    localparam logic [PROB_W-1:0] PROB_TBL [PROB_TBL_N] = '{
        17'd65536, 17'd52057, 17'd41350, 17'd32846, 17'd26090,
        17'd20724, 17'd16462, 17'd13076, 17'd10387, 17'd8250,
        17'd6554,  17'd5206,  17'd4135,  17'd3285,  17'd2609,
        17'd2072,  17'd1646,  17'd1308,  17'd1039,  17'd825,
        17'd655,   17'd521,   17'd414,   17'd328,   17'd261,
        17'd207,   17'd165,   17'd131,   17'd104,   17'd83,
        17'd66,    17'd52,    17'd41,    17'd33,    17'd26,
        17'd21,    17'd16,    17'd13,    17'd10,    17'd8,
        17'd7,     17'd5,     17'd4,     17'd3,     17'd3,
        17'd2,     17'd2,     17'd1,     17'd1,     17'd1,
        17'd1,     17'd1
    };

    // Error probability of a phred quality, Q0.16
    function automatic logic [PROB_W-1:0] err_prob(input logic [QUAL_W-1:0] q);
        logic [PROB_W-1:0] p;
        if (q < QUAL_W'(PROB_TBL_N)) begin
            p = PROB_TBL[q[5:0]];
        end else begin
            p = '0;
        end
        return p;
    endfunction

endpackage

FILE: design/rqt_if.sv
// Valid/ready channel interfaces for quality bases in and trim bounds out.
interface rqt_in_if
    import rqt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [QUAL_W-1:0] quality;
    logic              is_last;

    modport source (output valid, output quality, output is_last, input ready);
    modport sink   (input valid, input quality, input is_last, output ready);
endinterface

interface rqt_out_if
    import rqt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] trim_start;
    logic [LEN_W-1:0] trim_end;

    modport source (output valid, output trim_start, output trim_end, input ready);
    modport sink   (input valid, input trim_start, input trim_end, output ready);
endinterface

FILE: design/rqt_track.sv
// Per-base score tracking: running segment, best segment and base position.
module rqt_track
    import rqt_pkg::*;
#(
    parameter int MAX_LEN = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_proc,
    input  t_base                      i_base,
    input  logic [MINP_W-1:0]          i_min_prob,
    input  logic [LEN_W-1:0]           i_first_pos,
    input  logic [LEN_W-1:0]           i_last_pos,
    output logic [$clog2(MAX_LEN+1)-1:0] o_fin_start,
    output logic [$clog2(MAX_LEN+1)-1:0] o_fin_end,
    output logic [QSUM_W-1:0]          o_fin_qual
);

    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int CW = (PW > LEN_W) ? PW : LEN_W;
    localparam int SW = SUM_W + 2;
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_LEN);

    logic [PW-1:0]     r_pos, n_pos;
    logic [SUM_W-1:0]  r_run_sum, n_run_sum;
    logic [QSUM_W-1:0] r_run_qual, n_run_qual;
    logic [PW-1:0]     r_run_start, n_run_start;
    logic [SUM_W-1:0]  r_best_sum, n_best_sum;
    logic [QSUM_W-1:0] r_best_qual, n_best_qual;
    logic [PW-1:0]     r_best_start, n_best_start;
    logic [PW-1:0]     r_best_end, n_best_end;

    logic [PW-1:0]       cur_start;
    logic [PW-1:0]       pos_inc;
    logic                in_win;
    logic signed [SW-1:0] score;
    logic [QSUM_W:0]     qual_add;
    logic [QSUM_W-1:0]   qual_sat;
    logic [SUM_W-1:0]    upd_sum;
    logic [QSUM_W-1:0]   upd_qual;
    logic [PW-1:0]       upd_start;

    // Window test and the run start seen by this base
    always_comb begin
        cur_start = (r_pos == '0) ? PW'(i_first_pos) : r_run_start;
        pos_inc   = r_pos + PW'(1);
        in_win    = (CW'(r_pos) >= CW'(i_first_pos)) && (r_pos < POS_MAX) &&
                    ((i_last_pos == '0) || (CW'(r_pos) < CW'(i_last_pos)));
    end

    // Score add, quality total, and run restart on a non-positive sum
    always_comb begin
        score = $signed({2'b00, r_run_sum}) + $signed(SW'(i_min_prob))
              - $signed(SW'(err_prob(i_base.quality)));
        qual_add = {1'b0, r_run_qual} + (QSUM_W + 1)'(i_base.quality);
        qual_sat = qual_add[QSUM_W] ? QSUM_MAX : qual_add[QSUM_W-1:0];
        if (score <= 0) begin
            upd_sum   = '0;
            upd_qual  = '0;
            upd_start = pos_inc;
        end else begin
            upd_sum   = score[SUM_W] ? SUM_MAX : score[SUM_W-1:0];
            upd_qual  = qual_sat;
            upd_start = cur_start;
        end
    end

    // Best segment and next state
    always_comb begin
        n_pos        = (r_pos != POS_MAX) ? pos_inc : r_pos;
        n_run_sum    = r_run_sum;
        n_run_qual   = r_run_qual;
        n_run_start  = cur_start;
        n_best_sum   = r_best_sum;
        n_best_qual  = r_best_qual;
        n_best_start = r_best_start;
        n_best_end   = r_best_end;
        if (in_win) begin
            n_run_sum   = upd_sum;
            n_run_qual  = upd_qual;
            n_run_start = upd_start;
            if (upd_sum > r_best_sum) begin
                n_best_sum   = upd_sum;
                n_best_qual  = upd_qual;
                n_best_start = upd_start;
                n_best_end   = pos_inc;
            end
        end
    end

    assign o_fin_start = n_best_start;
    assign o_fin_end   = n_best_end;
    assign o_fin_qual  = n_best_qual;

    // State registers; the last base of a read clears everything
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_run_sum    <= '0;
            r_run_qual   <= '0;
            r_run_start  <= '0;
            r_best_sum   <= '0;
            r_best_qual  <= '0;
            r_best_start <= '0;
            r_best_end   <= '0;
        end else if (i_proc) begin
            if (i_base.is_last) begin
                r_pos        <= '0;
                r_run_sum    <= '0;
                r_run_qual   <= '0;
                r_run_start  <= '0;
                r_best_sum   <= '0;
                r_best_qual  <= '0;
                r_best_start <= '0;
                r_best_end   <= '0;
            end else begin
                r_pos        <= n_pos;
                r_run_sum    <= n_run_sum;
                r_run_qual   <= n_run_qual;
                r_run_start  <= n_run_start;
                r_best_sum   <= n_best_sum;
                r_best_qual  <= n_best_qual;
                r_best_start <= n_best_start;
                r_best_end   <= n_best_end;
            end
        end
    end

    // A best segment with a positive score always ends after it starts
    a_best_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_best_sum != '0) |-> (r_best_end > r_best_start))
        else $error("best segment end not past its start");

    // Position never passes its saturation point
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX)
        else $error("position beyond limit");

    // The last base of a read leaves the tracker cleared
    a_read_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_proc && i_base.is_last) |=> (r_pos == '0 && r_best_sum == '0))
        else $error("tracker not cleared after read end");

endmodule

FILE: design/rqt_judge.sv
// Final check of the best segment: minimum length and mean quality by multiplication.
module rqt_judge
    import rqt_pkg::*;
#(
    parameter int MAX_LEN = 4096
) (
    input  logic [$clog2(MAX_LEN+1)-1:0] i_start,
    input  logic [$clog2(MAX_LEN+1)-1:0] i_end,
    input  logic [QSUM_W-1:0]            i_qual,
    input  logic [AVG_W-1:0]             i_mean_floor,
    input  logic [LEN_W-1:0]             i_min_length,
    output logic [LEN_W-1:0]             o_trim_start,
    output logic [LEN_W-1:0]             o_trim_end
);

    localparam int PW = $clog2(MAX_LEN + 1);
    localparam int CW = (PW > LEN_W) ? PW : LEN_W;
    localparam int MW = AVG_W + PW;
    localparam int QW = (MW > QSUM_W) ? MW : QSUM_W;

    logic [PW-1:0] seg_len;
    logic [MW-1:0] need;
    logic          reject;

    // Length, required quality total, and the accept decision
    always_comb begin
        seg_len = (i_end > i_start) ? (i_end - i_start) : '0;
        need    = MW'(i_mean_floor) * MW'(seg_len);
        reject  = (CW'(seg_len) < CW'(i_min_length)) || (QW'(i_qual) < QW'(need));
        o_trim_start = reject ? '0 : LEN_W'(i_start);
        o_trim_end   = reject ? '0 : LEN_W'(i_end);
    end

endmodule

FILE: design/read_quality_trimmer_top.sv
// Read quality trimmer: one base per cycle, best-segment search with a trim result per read.
//
// Each transaction on the input channel carries one phred quality; the block accepts one
// every clock cycle except during the read-end stall below. A base passes an input
// register, then updates the segment tracker (one table lookup, a 34-bit add and a 32-bit
// compare). The base marked is_last hands the best segment to a final register, and the
// length / mean-quality check (a 7 x 13-bit multiply and compare) fills the output
// register from it, so a trim result goes from the input register through the final and
// output registers. Bases that are not the last keep flowing while results wait on the
// output; a read end stalls input only while both result registers are full and the output
// is blocked. Configuration writes take effect at once and are meant for the idle time
// between reads. Positions from MAX_LEN on are not scored.
module read_quality_trimmer_top
    import rqt_pkg::*;
#(
    parameter int MAX_LEN = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rqt_in_if.sink                i_in_ch,
    rqt_out_if.source             o_out_ch
);

    localparam int PW = $clog2(MAX_LEN + 1);

    // Configuration registers
    logic [MINP_W-1:0] r_min_prob;
    logic [AVG_W-1:0]  r_mean_floor;
    logic [LEN_W-1:0]  r_min_length;
    logic [LEN_W-1:0]  r_first_pos;
    logic [LEN_W-1:0]  r_last_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_prob     <= MINP_W'(3277);
            r_mean_floor   <= AVG_W'(10);
            r_min_length   <= LEN_W'(50);
            r_first_pos    <= '0;
            r_last_pos     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_PROB:     r_min_prob     <= i_cfg_data[MINP_W-1:0];
                CFG_MIN_AVG_QUAL: r_mean_floor   <= i_cfg_data[AVG_W-1:0];
                CFG_MIN_LENGTH:   r_min_length   <= i_cfg_data[LEN_W-1:0];
                CFG_FIRST_POS:    r_first_pos    <= i_cfg_data[LEN_W-1:0];
                CFG_LAST_POS:     r_last_pos     <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control
    logic r_in_valid;
    t_base r_in_base;
    logic r_fin_valid;
    logic [PW-1:0]     r_fin_start;
    logic [PW-1:0]     r_fin_end;
    logic [QSUM_W-1:0] r_fin_qual;
    logic r_out_valid;
    logic [LEN_W-1:0] r_out_start;
    logic [LEN_W-1:0] r_out_end;

    logic out_free;
    logic fin_free;
    logic proc;
    logic in_take;

    assign out_free = !r_out_valid || o_out_ch.ready;
    assign fin_free = !r_fin_valid || out_free;
    assign proc     = r_in_valid && (!r_in_base.is_last || fin_free);
    assign in_take  = i_in_ch.valid && i_in_ch.ready;
    assign i_in_ch.ready = !r_in_valid || proc;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_base <= '{quality: i_in_ch.quality, is_last: i_in_ch.is_last};
        end
    end

    // Segment tracker
    logic [PW-1:0]     fin_start;
    logic [PW-1:0]     fin_end;
    logic [QSUM_W-1:0] fin_qual;

    rqt_track #(
        .MAX_LEN (MAX_LEN)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_proc      (proc),
        .i_base      (r_in_base),
        .i_min_prob  (r_min_prob),
        .i_first_pos (r_first_pos),
        .i_last_pos  (r_last_pos),
        .o_fin_start (fin_start),
        .o_fin_end   (fin_end),
        .o_fin_qual  (fin_qual)
    );

    // Best segment of a finished read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (proc && r_in_base.is_last) begin
            r_fin_valid <= 1'b1;
        end else if (out_free) begin
            r_fin_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in_base.is_last) begin
            r_fin_start <= fin_start;
            r_fin_end   <= fin_end;
            r_fin_qual  <= fin_qual;
        end
    end

    // Final check into the output register
    logic [LEN_W-1:0] judge_start;
    logic [LEN_W-1:0] judge_end;

    rqt_judge #(
        .MAX_LEN (MAX_LEN)
    ) u_judge (
        .i_start        (r_fin_start),
        .i_end          (r_fin_end),
        .i_qual         (r_fin_qual),
        .i_mean_floor   (r_mean_floor),
        .i_min_length   (r_min_length),
        .o_trim_start   (judge_start),
        .o_trim_end     (judge_end)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_fin_valid) begin
            r_out_start <= judge_start;
            r_out_end   <= judge_end;
        end
    end

    assign o_out_ch.valid      = r_out_valid;
    assign o_out_ch.trim_start = r_out_start;
    assign o_out_ch.trim_end   = r_out_end;

    // A finished read waits in place while the output register is blocked
    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin_valid && !out_free) |=> r_fin_valid)
        else $error("finished read lost while output stalled");

    // A read end is only processed when the final register can take it
    a_fin_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_base.is_last) |-> fin_free)
        else $error("read end processed without room for its result");

    // A read end reaches the output register when nothing is in the way
    a_fin_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fin_valid && out_free) |=> r_out_valid)
        else $error("finished read did not reach the output");

    // A stalled input register blocks the input channel
    a_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !proc) |-> !i_in_ch.ready)
        else $error("input accepted while input register stalled");

endmodule
